FILE: rtl/core/nfra_pkg.sv
// Shared constants, status codes and helper functions for the next-fit run allocator.
// Depends on nothing; the allocator top level imports it.
package nfra_pkg;

	localparam int CAPACITY = 1024;
	localparam int MAX_RUN  = 16;

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int SIZE_W = IDX_W + 1;
	localparam int CNT_W  = $clog2(MAX_RUN + 1);
	localparam int WORD_W = 32;
	localparam int OFF_W  = $clog2(WORD_W);
	localparam int ROWS   = CAPACITY / WORD_W;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int PTR_W  = ROW_W + 1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_GREW      = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;
	localparam logic [1:0] ST_BAD_COUNT = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	// Clamp a register value to 1..CAPACITY and round it down to a power of two.
	function automatic logic [SIZE_W-1:0] size_from_reg(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] v;
		logic [SIZE_W-1:0] p;
		v = raw;
		if (v == '0) begin
			v = SIZE_W'(1);
		end
		if (v > SIZE_W'(CAPACITY)) begin
			v = SIZE_W'(CAPACITY);
		end
		p = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (v[i]) begin
				p = SIZE_W'(1) << i;
			end
		end
		return p;
	endfunction

	// Mask of the entries of a word that lie below an active size of n.
	function automatic word_t low_mask(input logic [SIZE_W-1:0] n);
		word_t m;
		if (n >= SIZE_W'(WORD_W)) begin
			m = '1;
		end else begin
			m = ~({WORD_W{1'b1}} << n[OFF_W-1:0]);
		end
		return m;
	endfunction

	localparam logic [SIZE_W-1:0] SIZE_RESET = size_from_reg(SIZE_W'(64));

endpackage

FILE: rtl/core/next_fit_run_allocator_top.sv
// Top level of the next-fit run allocator: bitmap memory, word scanner and sequencer.
// Depends on nfra_pkg for widths, status codes and the size helper functions.
//
// Usage. A word on the input channel is either an allocate (kind 0) asking for a
// run of run_count contiguous free entries, or a release (kind 1) that frees
// run_count entries from start_index. Each input word gives exactly one result
// word: entry_index, status and the active table size after the step. Both
// channels use valid and stall; a word moves at an edge with valid high and
// stall low. The size register is written through cfg_write_en and cfg_write_data
// and loads the active size at once; the user must write it only while idle (no check).
//
// Timing. One item is in flight at a time; in_stall is high from acceptance
// until its result is in the output register. The bitmap lives in a 32-bit wide
// memory with a registered read port, and the search walks it one word per
// cycle. An allocate scans from the hint word to the end of the active size and,
// on a miss, from word zero to the end; after a second miss it decides on growth,
// then marks each touched word by a read-modify-write. The worst case is a miss
// at full size that ends in no_space; the search is far shorter when the hint
// word holds a fit. A release does a read-modify-write of each touched word; a
// bad count goes straight to the result.
//
// Reset clears every row valid bit, so the whole map reads as free without a
// clearing pass; the hint resets to zero and the size to 64. When the receiver
// stalls, the result holds in the output register and the next input word may
// be accepted, but its own result waits until the register has drained.
module next_fit_run_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [nfra_pkg::SIZE_W-1:0]   cfg_write_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [nfra_pkg::IDX_W-1:0]    start_index,
	input  logic [nfra_pkg::CNT_W-1:0]    run_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nfra_pkg::IDX_W-1:0]    entry_index,
	output logic [1:0]                    status,
	output logic [nfra_pkg::SIZE_W-1:0]   active_entries
);
	import nfra_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_GROW = 3'd2;
	localparam logic [2:0] S_MRD  = 3'd3;
	localparam logic [2:0] S_MWR  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;

	// Architectural state. The map itself is the memory plus one valid bit per
	// row; a row whose valid bit is clear reads as all free.
	word_t              mem_q [ROWS];
	logic [ROWS-1:0]    row_vld_q;
	logic [IDX_W-1:0]   hint_q;
	logic [SIZE_W-1:0]  size_q;

	// Item being worked on.
	logic [CNT_W-1:0]   cnt_q;
	logic               pass2_q;
	logic [PTR_W-1:0]   ptr_q;
	logic [MAX_RUN-1:0] hist_q;
	logic [SIZE_W-1:0]  mk_start_q;
	logic [SIZE_W-1:0]  mk_end_q;
	logic               mk_set_q;
	logic [ROW_W-1:0]   mw_q;
	word_t              grow_clr_q;
	logic [IDX_W-1:0]   res_entry_q;
	logic [1:0]         res_status_q;

	// Read pipeline.
	word_t              rdata_s1;
	logic               rowv_s1;
	logic               vld_s1;
	logic [ROW_W-1:0]   addr_s1;

	// Output register.
	logic               out_valid_q;
	logic [IDX_W-1:0]   entry_q;
	logic [1:0]         status_q;
	logic [SIZE_W-1:0]  active_q;

	logic [ROW_W-1:0]   raddr;
	logic [SIZE_W-1:0]  size_m1;
	logic [ROW_W-1:0]   last_row;
	logic [SIZE_W-1:0]  cfg_size;

	// Scanner signals.
	word_t              scan_word;
	word_t              amask;
	word_t              hmask;
	word_t              free_bits;
	logic [WORD_W+MAX_RUN-1:0] win;
	logic [MAX_RUN-1:0] cmask;
	word_t              ok_bits;
	logic               hit_any;
	logic [OFF_W-1:0]   hit_off;
	logic               hit;
	logic [SIZE_W-1:0]  hit_start;
	logic [SIZE_W-1:0]  hit_end;
	logic               scan_issue;
	logic               scan_end;

	// Mark signals.
	word_t              mark_word;
	word_t              sel_bits;
	word_t              clr_bits;
	word_t              mem_wdata;
	logic               mem_we;
	logic [SIZE_W-1:0]  run_last;
	logic [SIZE_W-OFF_W-1:0] run_last_row;
	logic               mark_done;
	logic [IDX_W-1:0]   hint_new;

	// Growth signals.
	logic [SIZE_W-1:0]  grown;
	logic               can_grow;
	logic               out_free;

	assign size_m1  = size_q - SIZE_W'(1);
	assign last_row = size_m1[IDX_W-1:OFF_W];
	assign cfg_size = size_from_reg(cfg_write_data);
	assign raddr    = (state_q == S_SCAN) ? ptr_q[ROW_W-1:0] : mw_q;
	assign out_free = !out_valid_q || !out_stall;

	// Word scanner. A run of cnt entries ending at bit j is free when the cnt
	// bits ending there, reaching back into the history of earlier words, are
	// all free. The lowest such end gives the lowest start. On the first pass
	// entries below the hint are treated as taken, so any hit starts at or after
	// the hint.
	always_comb begin
		scan_word = rowv_s1 ? rdata_s1 : '0;
		amask     = low_mask(size_q);
		if (!pass2_q && addr_s1 == hint_q[IDX_W-1:OFF_W]) begin
			hmask = {WORD_W{1'b1}} << hint_q[OFF_W-1:0];
		end else begin
			hmask = '1;
		end
		free_bits = ~scan_word & amask & hmask;
		win       = {free_bits, hist_q};
		cmask     = {MAX_RUN{1'b1}} << (CNT_W'(MAX_RUN) - cnt_q);
		for (int j = 0; j < WORD_W; j++) begin
			ok_bits[j] = ((~win[j+1 +: MAX_RUN]) & cmask) == '0;
		end
		hit_any = 1'b0;
		hit_off = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (ok_bits[j]) begin
				hit_any = 1'b1;
				hit_off = OFF_W'(j);
			end
		end
		hit        = (state_q == S_SCAN) && vld_s1 && hit_any;
		hit_start  = SIZE_W'({addr_s1, hit_off}) + SIZE_W'(1) - SIZE_W'(cnt_q);
		hit_end    = hit_start + SIZE_W'(cnt_q);
		scan_issue = (state_q == S_SCAN) && !hit && (ptr_q <= {1'b0, last_row});
		scan_end   = (state_q == S_SCAN) && vld_s1 && !hit_any && (addr_s1 == last_row);
	end

	// Read-modify-write of one map word: set or clear the run's bits that fall in
	// this word and inside the active size, and clear the entries that a growth
	// from a small table brought in.
	always_comb begin
		mark_word = rowv_s1 ? rdata_s1 : '0;
		for (int j = 0; j < WORD_W; j++) begin
			sel_bits[j] = (SIZE_W'({mw_q, OFF_W'(j)}) >= mk_start_q)
				&& (SIZE_W'({mw_q, OFF_W'(j)}) < mk_end_q)
				&& (SIZE_W'({mw_q, OFF_W'(j)}) < size_q);
		end
		clr_bits = (mw_q == '0) ? grow_clr_q : '0;
		if (mk_set_q) begin
			mem_wdata = (mark_word & ~clr_bits) | sel_bits;
		end else begin
			mem_wdata = mark_word & ~clr_bits & ~sel_bits;
		end
		mem_we       = (state_q == S_MWR);
		run_last     = mk_end_q - SIZE_W'(1);
		run_last_row = run_last[SIZE_W-1:OFF_W];
		mark_done    = ({1'b0, mw_q} >= run_last_row) || (mw_q >= last_row);
		if (mk_end_q > size_m1) begin
			hint_new = size_m1[IDX_W-1:0];
		end else begin
			hint_new = mk_end_q[IDX_W-1:0];
		end
	end

	assign grown    = size_q << 1;
	assign can_grow = (size_q != SIZE_W'(CAPACITY)) && (SIZE_W'(cnt_q) <= size_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mw_q] <= mem_wdata;
		end
		rdata_s1 <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_vld_q    <= '0;
			hint_q       <= '0;
			size_q       <= SIZE_RESET;
			rowv_s1      <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rowv_s1 <= row_vld_q[raddr];
			vld_s1  <= scan_issue;
			if (scan_issue) begin
				addr_s1 <= ptr_q[ROW_W-1:0];
			end
			// In the done state the output register is reloaded instead.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q      <= run_count;
						hist_q     <= '0;
						pass2_q    <= 1'b0;
						grow_clr_q <= '0;
						res_entry_q  <= '0;
						if (run_count == '0 || run_count > CNT_W'(MAX_RUN)) begin
							res_status_q <= ST_BAD_COUNT;
							state_q      <= S_DONE;
						end else if (kind) begin
							res_status_q <= ST_OK;
							mk_start_q <= SIZE_W'(start_index);
							mk_end_q   <= SIZE_W'(start_index) + SIZE_W'(run_count);
							mk_set_q   <= 1'b0;
							mw_q       <= start_index[IDX_W-1:OFF_W];
							state_q    <= S_MRD;
						end else begin
							res_status_q <= ST_OK;
							ptr_q   <= {1'b0, hint_q[IDX_W-1:OFF_W]};
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_entry_q <= hit_start[IDX_W-1:0];
						mk_start_q  <= hit_start;
						mk_end_q    <= hit_end;
						mk_set_q    <= 1'b1;
						mw_q        <= hit_start[IDX_W-1:OFF_W];
						state_q     <= S_MRD;
					end else if (scan_end) begin
						if (!pass2_q) begin
							pass2_q <= 1'b1;
							ptr_q   <= '0;
							hist_q  <= '0;
						end else begin
							state_q <= S_GROW;
						end
					end else begin
						if (scan_issue) begin
							ptr_q <= ptr_q + PTR_W'(1);
						end
						if (vld_s1) begin
							hist_q <= win[WORD_W+MAX_RUN-1 -: MAX_RUN];
						end
					end
				end
				S_GROW: begin
					if (can_grow) begin
						size_q <= grown;
						if (size_q >= SIZE_W'(WORD_W)) begin
							for (int r = 0; r < ROWS; r++) begin
								if (SIZE_W'(r) >= (size_q >> OFF_W)
									&& SIZE_W'(r) < (grown >> OFF_W)) begin
									row_vld_q[r] <= 1'b0;
								end
							end
						end else begin
							grow_clr_q <= low_mask(grown) & ~low_mask(size_q);
						end
						res_status_q <= ST_GREW;
						res_entry_q  <= size_q[IDX_W-1:0];
						mk_start_q   <= size_q;
						mk_end_q     <= size_q + SIZE_W'(cnt_q);
						mk_set_q     <= 1'b1;
						mw_q         <= size_q[IDX_W-1:OFF_W];
						state_q      <= S_MRD;
					end else begin
						res_status_q <= ST_NO_SPACE;
						res_entry_q  <= '0;
						state_q      <= S_DONE;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					row_vld_q[mw_q] <= 1'b1;
					if (mark_done) begin
						if (mk_set_q) begin
							hint_q <= hint_new;
						end
						state_q <= S_DONE;
					end else begin
						mw_q    <= mw_q + ROW_W'(1);
						state_q <= S_MRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						entry_q     <= res_entry_q;
						status_q    <= res_status_q;
						active_q    <= size_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Register writes must arrive only while the block is idle; the block does not check it.
			if (cfg_write_en) begin
				size_q <= cfg_size;
				if (SIZE_W'(hint_q) >= cfg_size) begin
					hint_q <= IDX_W'(cfg_size - SIZE_W'(1));
				end
			end
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign entry_index    = entry_q;
	assign status         = status_q;
	assign active_entries = active_q;

`ifndef ASSERT_OFF
	a_hint_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		SIZE_W'(hint_q) < size_q)
		else $error("search hint outside the active size");

	a_size_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(size_q))
		else $error("active size is not a power of two");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && vld_s1) |-> (addr_s1 <= last_row))
		else $error("scanner evaluated a word beyond the active size");

	a_entry_in_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (SIZE_W'(entry_q) < active_q))
		else $error("reported entry lies outside the reported size");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_NO_SPACE || status_q == ST_BAD_COUNT))
		|-> (entry_q == '0))
		else $error("failed step reported a nonzero entry");
`endif

endmodule
